// ===== src/assert_macros.svh =====
// Assertion macros used by the result buffer (jsu_out) of the JSON string decoder.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a condition at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rstn, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (cond)) else $error(msg);

// Checks that a trigger in one cycle is followed by a condition in the next.
`define ASSERT_NEXT(lbl, clk, rstn, trig, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (trig) |=> (cond)) else $error(msg);

`endif

// ===== src/jsu_pkg.sv =====
// Types and constants shared by the JSON string decoder modules.
package jsu_pkg;

    localparam int unsigned LEN_W = 24;
    localparam int unsigned BYTE_W = 8;
    localparam int unsigned GROUP_MAX = 4;

    localparam logic [LEN_W-1:0] MAX_LEN_RESET = 24'hffffff;

    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5c;
    localparam logic [7:0] CH_SLASH = 8'h2f;
    localparam logic [7:0] CH_B = 8'h62;
    localparam logic [7:0] CH_F = 8'h66;
    localparam logic [7:0] CH_N = 8'h6e;
    localparam logic [7:0] CH_R = 8'h72;
    localparam logic [7:0] CH_T = 8'h74;
    localparam logic [7:0] CH_U = 8'h75;
    localparam logic [7:0] CTRL_LIMIT = 8'h20;

    localparam logic [7:0] CODE_BS = 8'h08;
    localparam logic [7:0] CODE_FF = 8'h0c;
    localparam logic [7:0] CODE_LF = 8'h0a;
    localparam logic [7:0] CODE_CR = 8'h0d;
    localparam logic [7:0] CODE_TAB = 8'h09;

    localparam logic [15:0] SUR_HI_FIRST = 16'hd800;
    localparam logic [15:0] SUR_HI_LAST = 16'hdbff;
    localparam logic [15:0] SUR_LO_FIRST = 16'hdc00;
    localparam logic [15:0] SUR_LO_LAST = 16'hdfff;
    localparam logic [20:0] SUPP_BASE = 21'h10000;

    localparam logic [7:0] UTF_LEAD2 = 8'hc0;
    localparam logic [7:0] UTF_LEAD3 = 8'he0;
    localparam logic [7:0] UTF_LEAD4 = 8'hf0;
    localparam logic [7:0] UTF_CONT = 8'h80;

    typedef enum logic [1:0] {
        ST_DATA = 2'd0,
        ST_DONE = 2'd1,
        ST_ERR  = 2'd2
    } t_status;

    typedef enum logic [6:0] {
        PH_IDLE = 7'b0000001,
        PH_BODY = 7'b0000010,
        PH_ESC  = 7'b0000100,
        PH_HEX1 = 7'b0001000,
        PH_BSL  = 7'b0010000,
        PH_LOWU = 7'b0100000,
        PH_HEX2 = 7'b1000000
    } t_phase;

    typedef struct packed {
        logic [BYTE_W-1:0] in_byte;
        logic              input_end;
    } t_in_item;

    typedef struct packed {
        logic [BYTE_W-1:0] out_byte;
        t_status           status;
        logic [LEN_W-1:0]  out_length;
        logic              run_last;
    } t_out_item;

    typedef struct packed {
        t_phase           phase;
        logic [15:0]      hex_accum;
        logic [1:0]       digit_count;
        logic [9:0]       high_surrogate;
        logic [LEN_W-1:0] byte_count;
    } t_state;

    typedef struct packed {
        logic [2:0]                       count;
        logic [GROUP_MAX-1:0][BYTE_W-1:0] bytes;
        t_status                          status;
        logic [LEN_W-1:0]                 length;
    } t_group;

endpackage

// ===== src/jsu_decode.sv =====
// Decoder logic: next state and the result group for one input byte.
module jsu_decode
    import jsu_pkg::*;
(
    input  t_state           i_state,
    input  t_in_item         i_item,
    input  logic [LEN_W-1:0] i_max_len,
    output t_state           o_next,
    output t_group           o_group
);

    function automatic logic [4:0] hex_nibble(input logic [7:0] c);
        logic [4:0] r;
        r = 5'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            r = {1'b1, c[3:0]};
        end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
            r = {1'b1, c[3:0] + 4'd9};
        end
        return r;
    endfunction

    logic [7:0]                       w_c;
    logic [4:0]                       w_hex;
    logic [15:0]                      w_acc;
    logic [20:0]                      w_cp;
    logic                             w_cp_emit;
    logic                             w_single;
    logic [7:0]                       w_one;
    logic                             w_fail;
    logic                             w_done;
    logic [2:0]                       w_n;
    logic [GROUP_MAX-1:0][BYTE_W-1:0] w_b;
    logic [LEN_W:0]                   w_sum;

    assign w_c = i_item.in_byte;
    assign w_hex = hex_nibble(w_c);
    assign w_acc = {i_state.hex_accum[11:0], w_hex[3:0]};

    always_comb begin
        o_next = i_state;
        w_fail = 1'b0;
        w_done = 1'b0;
        w_cp_emit = 1'b0;
        w_single = 1'b0;
        w_one = 8'd0;
        w_cp = 21'd0;
        unique case (i_state.phase)
            PH_BODY: begin
                if (i_item.input_end) begin
                    w_fail = 1'b1;
                end else if (w_c == CH_QUOTE) begin
                    w_done = 1'b1;
                    o_next.phase = PH_IDLE;
                end else if (w_c < CTRL_LIMIT) begin
                    w_fail = 1'b1;
                end else if (w_c == CH_BSLASH) begin
                    o_next.phase = PH_ESC;
                end else begin
                    w_single = 1'b1;
                    w_one = w_c;
                end
            end
            PH_ESC: begin
                if (i_item.input_end) begin
                    w_fail = 1'b1;
                end else begin
                    unique case (w_c)
                        CH_QUOTE, CH_BSLASH, CH_SLASH: begin
                            w_single = 1'b1;
                            w_one = w_c;
                        end
                        CH_B: begin
                            w_single = 1'b1;
                            w_one = CODE_BS;
                        end
                        CH_F: begin
                            w_single = 1'b1;
                            w_one = CODE_FF;
                        end
                        CH_N: begin
                            w_single = 1'b1;
                            w_one = CODE_LF;
                        end
                        CH_R: begin
                            w_single = 1'b1;
                            w_one = CODE_CR;
                        end
                        CH_T: begin
                            w_single = 1'b1;
                            w_one = CODE_TAB;
                        end
                        CH_U: begin
                            o_next.hex_accum = 16'd0;
                            o_next.digit_count = 2'd0;
                            o_next.phase = PH_HEX1;
                        end
                        default: begin
                            w_fail = 1'b1;
                        end
                    endcase
                end
            end
            PH_BSL: begin
                if (i_item.input_end || w_c != CH_BSLASH) begin
                    w_fail = 1'b1;
                end else begin
                    o_next.phase = PH_LOWU;
                end
            end
            PH_LOWU: begin
                if (i_item.input_end || w_c != CH_U) begin
                    w_fail = 1'b1;
                end else begin
                    o_next.hex_accum = 16'd0;
                    o_next.digit_count = 2'd0;
                    o_next.phase = PH_HEX2;
                end
            end
            PH_HEX1, PH_HEX2: begin
                if (i_item.input_end || !w_hex[4]) begin
                    w_fail = 1'b1;
                end else begin
                    o_next.hex_accum = w_acc;
                    if (i_state.digit_count != 2'd3) begin
                        o_next.digit_count = i_state.digit_count + 2'd1;
                    end else begin
                        o_next.digit_count = 2'd0;
                        if (i_state.phase == PH_HEX1) begin
                            if (w_acc >= SUR_HI_FIRST && w_acc <= SUR_HI_LAST) begin
                                o_next.high_surrogate = w_acc[9:0];
                                o_next.phase = PH_BSL;
                            end else if (w_acc >= SUR_LO_FIRST && w_acc <= SUR_LO_LAST) begin
                                w_fail = 1'b1;
                            end else begin
                                w_cp_emit = 1'b1;
                                w_cp = {5'd0, w_acc};
                            end
                        end else if (w_acc < SUR_LO_FIRST || w_acc > SUR_LO_LAST) begin
                            w_fail = 1'b1;
                        end else begin
                            w_cp_emit = 1'b1;
                            w_cp = SUPP_BASE + {1'b0, i_state.high_surrogate, w_acc[9:0]};
                        end
                    end
                end
            end
            default: begin
                o_next.phase = PH_IDLE;
                if (!i_item.input_end) begin
                    if (w_c != CH_QUOTE) begin
                        w_fail = 1'b1;
                    end else begin
                        o_next.byte_count = '0;
                        o_next.phase = PH_BODY;
                    end
                end
            end
        endcase

        w_b = '0;
        w_n = 3'd0;
        if (w_single) begin
            w_n = 3'd1;
            w_b[0] = w_one;
        end else if (w_cp_emit) begin
            if (w_cp <= 21'h7f) begin
                w_n = 3'd1;
                w_b[0] = w_cp[7:0];
            end else if (w_cp <= 21'h7ff) begin
                w_n = 3'd2;
                w_b[0] = UTF_LEAD2 | {3'd0, w_cp[10:6]};
                w_b[1] = UTF_CONT | {2'd0, w_cp[5:0]};
            end else if (w_cp <= 21'hffff) begin
                w_n = 3'd3;
                w_b[0] = UTF_LEAD3 | {4'd0, w_cp[15:12]};
                w_b[1] = UTF_CONT | {2'd0, w_cp[11:6]};
                w_b[2] = UTF_CONT | {2'd0, w_cp[5:0]};
            end else begin
                w_n = 3'd4;
                w_b[0] = UTF_LEAD4 | {5'd0, w_cp[20:18]};
                w_b[1] = UTF_CONT | {2'd0, w_cp[17:12]};
                w_b[2] = UTF_CONT | {2'd0, w_cp[11:6]};
                w_b[3] = UTF_CONT | {2'd0, w_cp[5:0]};
            end
        end

        w_sum = {1'b0, i_state.byte_count} + {{(LEN_W-2){1'b0}}, w_n};
        if (w_n != 3'd0) begin
            if (w_sum > {1'b0, i_max_len}) begin
                w_fail = 1'b1;
            end else begin
                o_next.byte_count = w_sum[LEN_W-1:0];
                o_next.phase = PH_BODY;
            end
        end

        o_group.bytes = w_b;
        o_group.count = w_n;
        o_group.status = ST_DATA;
        o_group.length = '0;
        if (w_fail) begin
            o_next.phase = PH_IDLE;
            o_group.bytes = '0;
            o_group.count = 3'd1;
            o_group.status = ST_ERR;
        end else if (w_done) begin
            o_group.count = 3'd1;
            o_group.status = ST_DONE;
            o_group.length = i_state.byte_count;
        end
    end

endmodule

// ===== src/jsu_out.sv =====
// Result buffer that holds one decoded group and hands it out one item per transaction.
`include "assert_macros.svh"

module jsu_out
    import jsu_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_load,
    input  t_group    i_group,
    input  logic      i_ready,
    output logic      o_valid,
    output logic      o_can_load,
    output t_out_item o_item
);

    logic [2:0]                       r_cnt;
    logic [2:0]                       n_cnt;
    logic [1:0]                       r_pos;
    logic [1:0]                       n_pos;
    logic [GROUP_MAX-1:0][BYTE_W-1:0] r_bytes;
    t_status                          r_status;
    logic [LEN_W-1:0]                 r_length;

    assign o_valid = (r_cnt != 3'd0);
    assign o_can_load = (r_cnt == 3'd0) || (r_cnt == 3'd1 && i_ready);

    assign o_item.out_byte = r_bytes[r_pos];
    assign o_item.status = r_status;
    assign o_item.out_length = r_length;
    assign o_item.run_last = (r_cnt == 3'd1);

    always_comb begin
        n_cnt = r_cnt;
        n_pos = r_pos;
        if (i_load) begin
            n_cnt = i_group.count;
            n_pos = 2'd0;
        end else if (o_valid && i_ready) begin
            n_cnt = r_cnt - 3'd1;
            n_pos = r_pos + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 3'd0;
            r_pos <= 2'd0;
        end else begin
            r_cnt <= n_cnt;
            r_pos <= n_pos;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_bytes <= i_group.bytes;
            r_status <= i_group.status;
            r_length <= i_group.length;
        end
    end

    `ASSERT_ALWAYS(a_cnt_range, i_clk, i_rst_n, r_cnt <= 3'd4, "result count out of range")
    `ASSERT_ALWAYS(a_ctl_single, i_clk, i_rst_n, !o_valid || r_status == ST_DATA || r_cnt == 3'd1, "completion or error group longer than one")
    `ASSERT_ALWAYS(a_load_free, i_clk, i_rst_n, !i_load || r_cnt == 3'd0 || (r_cnt == 3'd1 && i_ready), "group loaded over pending results")
    `ASSERT_NEXT(a_hold, i_clk, i_rst_n, o_valid && !i_ready && !i_load, o_valid && $stable(r_pos), "stalled result moved")

endmodule

// ===== src/json_string_unescape_utf8.sv =====
// Top level of the JSON string decoder: input register, state, limit register and result buffer.
// The first result of an input transaction passes the input register, then the result buffer,
// which presents it; a full buffer can hold the group back in the input register.
// One input transaction per cycle while the buffer can load; a group stays until its results go.
// A group has at most four results (a four-byte UTF-8 sequence); bytes with no result never stall.
// Reset is synchronous and active low: waiting for an opening quote, counters zero, buffers
// empty, and the length limit at its largest value.
module json_string_unescape_utf8
    import jsu_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  t_in_item         i_in,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output t_out_item        o_out,
    input  logic             i_cfg_valid,
    output logic             o_cfg_ready,
    input  logic [LEN_W-1:0] i_cfg_data
);

    logic             r_in_valid;
    t_in_item         r_in;
    t_state           r_state;
    t_state           w_next;
    logic [LEN_W-1:0] r_max;
    t_group           w_group;
    logic             w_can_load;
    logic             w_consume;
    logic             w_load;

    assign o_cfg_ready = 1'b1;

    jsu_decode u_decode (
        .i_state   (r_state),
        .i_item    (r_in),
        .i_max_len (r_max),
        .o_next    (w_next),
        .o_group   (w_group)
    );

    assign w_consume = r_in_valid && (w_group.count == 3'd0 || w_can_load);
    assign w_load = w_consume && (w_group.count != 3'd0);
    assign o_in_ready = !r_in_valid || w_consume;

    jsu_out u_out (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (w_load),
        .i_group    (w_group),
        .i_ready    (i_out_ready),
        .o_valid    (o_out_valid),
        .o_can_load (w_can_load),
        .o_item     (o_out)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_max <= MAX_LEN_RESET;
            r_state.phase <= PH_IDLE;
            r_state.hex_accum <= '0;
            r_state.digit_count <= '0;
            r_state.high_surrogate <= '0;
            r_state.byte_count <= '0;
        end else begin
            if (i_in_valid && o_in_ready) begin
                r_in_valid <= 1'b1;
            end else if (w_consume) begin
                r_in_valid <= 1'b0;
            end
            if (i_cfg_valid && o_cfg_ready) begin
                r_max <= i_cfg_data;
            end
            if (w_consume) begin
                r_state <= w_next;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in <= i_in;
        end
    end

endmodule
